/* sv/bts_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bts_pkg
// Shared types and constants of the bilinear texture sampler.
// ----------------------------------------------------------------------------
package bts_pkg;

  localparam int MAX_WIDTH_DEF  = 128;
  localparam int MAX_HEIGHT_DEF = 128;

  // Command queue between front and back (power of two)
  localparam int QUEUE_DEPTH = 2;

  // Configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

  // Input mode codes
  localparam logic MODE_WRITE  = 1'b0;
  localparam logic MODE_SAMPLE = 1'b1;

  // One classified item as handed from front to back
  typedef struct packed {
    logic        smp;    // sample when set, texel write otherwise
    logic [13:0] idx;    // write index
    logic [63:0] texel;  // alpha, blue, green, red from msb down
    logic [15:0] row0;   // y0 * width
    logic [15:0] row1;   // y1 * width
    logic [7:0]  x0;
    logic [7:0]  x1;
    logic [15:0] fu;
    logic [15:0] fv;
  } bts_cmd_t;

endpackage

/* sv/bts_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bts_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module bts_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16384
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* sv/bts_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bts_front
// Accepts items, drops out-of-range writes and works out the four texel
// positions and fractions of a sample before queueing the item.
// ----------------------------------------------------------------------------
module bts_front
  import bts_pkg::*;
#(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic        mode_i,
  input  logic [13:0] texel_index_i,
  input  logic [15:0] red_in_i,
  input  logic [15:0] green_in_i,
  input  logic [15:0] blue_in_i,
  input  logic [15:0] alpha_in_i,
  input  logic [15:0] u_coord_i,
  input  logic [15:0] v_coord_i,
  input  logic [7:0]  image_width_i,
  input  logic [7:0]  image_height_i,
  input  logic        full_i,
  output logic        push_o,
  output bts_cmd_t    cmd_o
);

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_ROW,
    ST_PUSH
  } state_e;

  function automatic logic [7:0] eff_size(logic [7:0] r, int lim);
    logic [7:0] s;
    if (r == 8'd0) begin
      s = 8'd1;
    end else if (int'(r) > lim) begin
      s = 8'(lim);
    end else begin
      s = r;
    end
    return s;
  endfunction

  state_e      state_q, state_d;
  bts_cmd_t    cmd_q, cmd_d;
  logic [15:0] u_q, v_q;
  logic [23:0] tu_q, tv_q;
  logic [7:0]  w_eff, h_eff;
  logic [7:0]  x0, y0;
  logic [8:0]  x_inc, y_inc;
  logic [7:0]  x1, y1;
  logic        accept;
  logic        in_range;

  assign w_eff = eff_size(image_width_i, MAX_WIDTH);
  assign h_eff = eff_size(image_height_i, MAX_HEIGHT);

  assign push_o = (state_q == ST_PUSH) && !full_i;
  assign busy   = !((state_q == ST_IDLE) || push_o);
  assign accept = start && !busy;
  assign in_range = int'(texel_index_i) < DEPTH;

  // integer part is already below the size, only the neighbour wraps
  assign x0    = tu_q[23:16];
  assign y0    = tv_q[23:16];
  assign x_inc = {1'b0, x0} + 9'd1;
  assign y_inc = {1'b0, y0} + 9'd1;
  assign x1    = (x_inc == {1'b0, w_eff}) ? 8'd0 : x_inc[7:0];
  assign y1    = (y_inc == {1'b0, h_eff}) ? 8'd0 : y_inc[7:0];

  always_comb begin
    state_d = state_q;
    cmd_d   = cmd_q;
    unique case (state_q)
      ST_IDLE, ST_PUSH: begin
        if (push_o) begin
          state_d = ST_IDLE;
        end
        if (accept) begin
          cmd_d.smp   = (mode_i == MODE_SAMPLE);
          cmd_d.idx   = texel_index_i;
          cmd_d.texel = {alpha_in_i, blue_in_i, green_in_i, red_in_i};
          if (mode_i == MODE_SAMPLE) begin
            state_d = ST_MUL;
          end else if (in_range) begin
            state_d = ST_PUSH;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_MUL: begin
        state_d = ST_ROW;
      end
      ST_ROW: begin
        cmd_d.x0   = x0;
        cmd_d.x1   = x1;
        cmd_d.row0 = y0 * w_eff;
        cmd_d.row1 = y1 * w_eff;
        cmd_d.fu   = tu_q[15:0];
        cmd_d.fv   = tv_q[15:0];
        state_d    = ST_PUSH;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
    if (accept) begin
      u_q <= u_coord_i;
      v_q <= v_coord_i;
    end
    if (state_q == ST_MUL) begin
      tu_q <= u_q * w_eff;
      tv_q <= v_q * h_eff;
    end
  end

  assign cmd_o = cmd_q;

endmodule

/* sv/bts_fifo.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bts_fifo
// Short command queue between front and back.
// ----------------------------------------------------------------------------
module bts_fifo
  import bts_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  bts_cmd_t cmd_i,
  output logic     full_o,
  input  logic     pop_i,
  output bts_cmd_t head_o,
  output logic     empty_o
);

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  bts_cmd_t        slot_q [QUEUE_DEPTH];
  logic [PW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CW-1:0]   cnt_q;

  assign full_o  = (cnt_q == CW'(QUEUE_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign head_o  = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + PW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + PW'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + CW'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= cmd_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !push_i || pop_i)
    else $error("command pushed into full queue");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    empty_o |-> !pop_i)
    else $error("command popped from empty queue");

endmodule

/* sv/bts_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bts_back
// Carries out queued items: texel writes into the store, and samples as four
// reads with two horizontal blends and one vertical blend.
// ----------------------------------------------------------------------------
module bts_back
  import bts_pkg::*;
#(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        empty_i,
  input  bts_cmd_t    head_i,
  output logic        pop_o,
  output logic        out_valid_o,
  output logic [15:0] red_out_o,
  output logic [15:0] green_out_o,
  output logic [15:0] blue_out_o,
  output logic [15:0] alpha_out_o
);

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(DEPTH);
  localparam int LW    = (AW > 16) ? AW : 16;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD1,
    ST_RD2,
    ST_RD3,
    ST_RD4
  } state_e;

  function automatic logic [AW-1:0] addr_of(logic [15:0] v);
    logic [LW-1:0] t;
    t = LW'(v);
    return t[AW-1:0];
  endfunction

  // a + ((b - a) * f + half) >> 16, floor shift on the signed difference
  function automatic logic [15:0] lerp(logic [15:0] a, logic [15:0] b, logic [15:0] f);
    logic signed [16:0] d;
    logic signed [33:0] p;
    logic signed [33:0] r;
    d = $signed({1'b0, b}) - $signed({1'b0, a});
    p = d * $signed({1'b0, f});
    r = (p + 34'sd32768) >>> 16;
    return 16'(r + $signed({18'b0, a}));
  endfunction

  state_e      state_q;
  bts_cmd_t    cmd_q;
  logic [63:0] a_q;
  logic [63:0] top_q;
  logic [63:0] vtop_q, vbot_q;
  logic [15:0] vfv_q;
  logic        vvld_q;
  logic [63:0] out_q;
  logic        out_vld_q;

  logic          ram_we;
  logic [AW-1:0] ram_addr;
  logic [63:0]   ram_rdata;
  logic [63:0]   hblend;
  logic [63:0]   vblend;
  logic          can_pop;

  assign can_pop = (state_q == ST_IDLE) || (state_q == ST_RD4);
  assign pop_o   = can_pop && !empty_i;
  assign ram_we  = pop_o && !head_i.smp;

  always_comb begin
    ram_addr = addr_of({2'b00, head_i.idx});
    unique case (state_q)
      ST_IDLE, ST_RD4: begin
        if (head_i.smp) begin
          ram_addr = addr_of(head_i.row0 + {8'd0, head_i.x0});
        end
      end
      ST_RD1:  ram_addr = addr_of(cmd_q.row0 + {8'd0, cmd_q.x1});
      ST_RD2:  ram_addr = addr_of(cmd_q.row1 + {8'd0, cmd_q.x0});
      ST_RD3:  ram_addr = addr_of(cmd_q.row1 + {8'd0, cmd_q.x1});
      default: ram_addr = addr_of({2'b00, head_i.idx});
    endcase
  end

  bts_ram #(
    .WIDTH(64),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .addr_i (ram_addr),
    .wdata_i(head_i.texel),
    .rdata_o(ram_rdata)
  );

  // shared horizontal unit: left texel held in a_q, right one from the store
  always_comb begin
    for (int ch = 0; ch < 4; ch++) begin
      hblend[16*ch +: 16] = lerp(a_q[16*ch +: 16], ram_rdata[16*ch +: 16], cmd_q.fu);
      vblend[16*ch +: 16] = lerp(vtop_q[16*ch +: 16], vbot_q[16*ch +: 16], vfv_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      vvld_q    <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      vvld_q    <= (state_q == ST_RD4);
      out_vld_q <= vvld_q;
      unique case (state_q)
        ST_IDLE, ST_RD4: begin
          if (pop_o && head_i.smp) begin
            state_q <= ST_RD1;
          end else begin
            state_q <= ST_IDLE;
          end
        end
        ST_RD1:  state_q <= ST_RD2;
        ST_RD2:  state_q <= ST_RD3;
        ST_RD3:  state_q <= ST_RD4;
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cmd_q <= head_i;
    end
    if (state_q == ST_RD1 || state_q == ST_RD3) begin
      a_q <= ram_rdata;
    end
    if (state_q == ST_RD2) begin
      top_q <= hblend;
    end
    if (state_q == ST_RD4) begin
      vtop_q <= top_q;
      vbot_q <= hblend;
      vfv_q  <= cmd_q.fv;
    end
    if (vvld_q) begin
      out_q <= vblend;
    end
  end

  assign out_valid_o = out_vld_q;
  assign red_out_o   = out_q[15:0];
  assign green_out_o = out_q[31:16];
  assign blue_out_o  = out_q[47:32];
  assign alpha_out_o = out_q[63:48];

  a_read_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_RD1 |=> state_q == ST_RD2 ##1 state_q == ST_RD3 ##1 state_q == ST_RD4)
    else $error("sample read sequence broken");

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_RD4 |=> ##1 out_valid_o)
    else $error("blended item not delivered");

endmodule

/* sv/bilinear_texture_sampler.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bilinear_texture_sampler
// Four-channel texture store with repeat-addressed bilinear sampling.
// ----------------------------------------------------------------------------
// Path: a sample passes the front's MUL, ROW and PUSH states, the queue, the
//   four reads and the blend registers; a texel write passes the front's
//   command register and the queue. Samples are paced by the four reads
//   of the single-port store; writes go one per cycle if the queue has room.
// Reset clears control state and sets both sizes to 128; store contents are
//   undefined until written. Results are strobed for one cycle, never held.
module bilinear_texture_sampler
  import bts_pkg::*;
#(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  logic                 mode_i,
  input  logic [13:0]          texel_index_i,
  input  logic [15:0]          red_in_i,
  input  logic [15:0]          green_in_i,
  input  logic [15:0]          blue_in_i,
  input  logic [15:0]          alpha_in_i,
  input  logic [15:0]          u_coord_i,
  input  logic [15:0]          v_coord_i,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [7:0]           cfg_data_i,
  output logic                 out_valid_o,
  output logic [15:0]          red_out_o,
  output logic [15:0]          green_out_o,
  output logic [15:0]          blue_out_o,
  output logic [15:0]          alpha_out_o
);

  logic [7:0] image_width_q, image_height_q;
  logic       push, pop, full, empty;
  bts_cmd_t   cmd, head;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      image_width_q  <= 8'd128;
      image_height_q <= 8'd128;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_IMAGE_WIDTH:  image_width_q  <= cfg_data_i;
        REG_IMAGE_HEIGHT: image_height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  bts_front #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .mode_i        (mode_i),
    .texel_index_i (texel_index_i),
    .red_in_i      (red_in_i),
    .green_in_i    (green_in_i),
    .blue_in_i     (blue_in_i),
    .alpha_in_i    (alpha_in_i),
    .u_coord_i     (u_coord_i),
    .v_coord_i     (v_coord_i),
    .image_width_i (image_width_q),
    .image_height_i(image_height_q),
    .full_i        (full),
    .push_o        (push),
    .cmd_o         (cmd)
  );

  bts_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .cmd_i  (cmd),
    .full_o (full),
    .pop_i  (pop),
    .head_o (head),
    .empty_o(empty)
  );

  bts_back #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .empty_i    (empty),
    .head_i     (head),
    .pop_o      (pop),
    .out_valid_o(out_valid_o),
    .red_out_o  (red_out_o),
    .green_out_o(green_out_o),
    .blue_out_o (blue_out_o),
    .alpha_out_o(alpha_out_o)
  );

endmodule
